// ----- rtl/static_buffer_loop_cursor_core_assert.svh -----
// Assertion macros for the loop cursor core.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef STATIC_BUFFER_LOOP_CURSOR_CORE_ASSERT_SVH
`define STATIC_BUFFER_LOOP_CURSOR_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SBLC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sblc assertion failed");

// Next-cycle implication, checked out of reset.
`define SBLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sblc assertion failed");

`endif

// ----- rtl/sblc_pkg.sv -----
// Shared types and constants of the loop cursor core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sblc_pkg;

  localparam logic [23:0] MAX_FRAMES = 24'd8388608;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET_POS = 2'd1,
    OP_RELOAD  = 2'd2,
    OP_LOADED  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_CAPACITY   = 3'd0,
    CFG_LOOP_START = 3'd1,
    CFG_LOOP_END   = 3'd2,
    CFG_LOOP_COUNT = 3'd3,
    CFG_PKT_FRAMES = 3'd4
  } cfg_idx_e;

  // Configuration registers; loop_reps is two's complement
  typedef struct packed {
    logic [23:0] cap_frames;
    logic [23:0] loop_start;
    logic [23:0] loop_end;
    logic [16:0] loop_reps;
    logic [12:0] packet_frames;
  } cfg_t;

  // Playback state; loops is two's complement, negative loops forever
  typedef struct packed {
    logic [23:0] cursor;
    logic [16:0] loops;
    logic        exhausted;
    logic        loaded;
    logic        cancelled;
    logic [12:0] pkt_cnt;
  } state_t;

  typedef struct packed {
    logic [22:0] frame_index;
    logic        frame_valid;
    logic        last_of_packet;
    logic        is_exhausted;
    logic        status;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/sblc_in_if.sv -----
// Input channel: one command transaction (op, frame).
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface sblc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [23:0] frame;

  modport source (output valid, output op, output frame, input ready);
  modport sink   (input valid, input op, input frame, output ready);
endinterface

`default_nettype wire

// ----- rtl/sblc_out_if.sv -----
// Output channel: one result transaction per command.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface sblc_out_if;
  logic        valid;
  logic        ready;
  logic [22:0] frame_index;
  logic        frame_valid;
  logic        last_of_packet;
  logic        is_exhausted;
  logic        status;

  modport source (output valid, output frame_index, output frame_valid,
                  output last_of_packet, output is_exhausted, output status,
                  input ready);
  modport sink   (input valid, input frame_index, input frame_valid,
                  input last_of_packet, input is_exhausted, input status,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/sblc_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface sblc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/sblc_cfg_regs.sv -----
// Configuration register file of the loop cursor core.
// Depends on sblc_pkg and sblc_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module sblc_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  sblc_cfg_if.sink           cfg_i,
  output sblc_pkg::cfg_t     cfg_o,
  output logic               reps_wr_o
);
  import sblc_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic wr_en;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d     = cfg_q;
    reps_wr_o = 1'b0;
    if (wr_en) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_CAPACITY:   cfg_d.cap_frames    = cfg_i.data;
        CFG_LOOP_START: cfg_d.loop_start    = cfg_i.data;
        CFG_LOOP_END:   cfg_d.loop_end      = cfg_i.data;
        CFG_LOOP_COUNT: begin
          cfg_d.loop_reps = cfg_i.data[16:0];
          reps_wr_o       = 1'b1;
        end
        CFG_PKT_FRAMES: cfg_d.packet_frames = cfg_i.data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cap_frames    <= 24'd1;
      cfg_q.loop_start    <= '0;
      cfg_q.loop_end      <= '0;
      cfg_q.loop_reps     <= '0;
      cfg_q.packet_frames <= 13'd480;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/sblc_step.sv -----
// Next-state and result logic for one command of the loop cursor core.
// Depends on sblc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sblc_step (
  input  wire sblc_pkg::cfg_t   cfg_i,
  input  wire sblc_pkg::state_t state_i,
  input  wire logic [1:0]       op_i,
  input  wire logic [23:0]      frame_i,
  output sblc_pkg::state_t      state_o,
  output sblc_pkg::res_t        res_o,
  output logic [23:0]           cap_o
);
  import sblc_pkg::*;

  logic [23:0] cap;
  logic [12:0] pkt;
  logic        loops_nz;
  logic        loops_pos;
  logic        loop_on;
  logic [23:0] boundary;
  logic [23:0] cur_inc;
  logic [13:0] cnt_inc;
  logic        wrap;
  logic        end_hit;
  logic        pkt_full;
  logic        close_w;
  logic        cancel_w;

  // Reposition the cursor and restart packet and loop bookkeeping
  function automatic state_t cursor_reset(state_t s, logic [23:0] target,
                                          logic [16:0] loop_cnt, logic [23:0] c);
    state_t r;
    r           = s;
    r.cursor    = target;
    r.loops     = s.cancelled ? 17'd0 : loop_cnt;
    r.exhausted = (target >= c);
    r.pkt_cnt   = '0;
    return r;
  endfunction

  // Clamp capacity, treat zero packet size as one
  assign cap   = (cfg_i.cap_frames > MAX_FRAMES) ? MAX_FRAMES : cfg_i.cap_frames;
  assign pkt   = (cfg_i.packet_frames == '0) ? 13'd1 : cfg_i.packet_frames;
  assign cap_o = cap;

  // Tick datapath: boundary check, advance, wrap and packet close
  assign loops_nz  = (state_i.loops != '0);
  assign loops_pos = loops_nz && !state_i.loops[16];
  assign loop_on   = loops_nz && (state_i.cursor < cfg_i.loop_end);
  assign boundary  = loop_on ? cfg_i.loop_end : cap;
  assign end_hit   = (state_i.cursor >= boundary) || (state_i.cursor >= cap);
  assign cur_inc   = state_i.cursor + 24'd1;
  assign cnt_inc   = {1'b0, state_i.pkt_cnt} + 14'd1;
  assign wrap      = (cur_inc == cfg_i.loop_end) && loops_nz;
  assign pkt_full  = (cnt_inc >= {1'b0, pkt});
  assign close_w   = (!wrap && (cur_inc >= cap)) || pkt_full;

  // Set position at or past the loop end cancels looping
  assign cancel_w = state_i.cancelled ||
                    ((cfg_i.loop_reps != '0) && (frame_i >= cfg_i.loop_end));

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    case (op_e'(op_i))
      OP_TICK: begin
        if (state_i.loaded && !state_i.exhausted) begin
          if (end_hit) begin
            state_o.exhausted    = 1'b1;
            state_o.pkt_cnt      = '0;
            res_o.last_of_packet = 1'b1;
          end else begin
            res_o.frame_index    = state_i.cursor[22:0];
            res_o.frame_valid    = 1'b1;
            res_o.last_of_packet = close_w;
            if (wrap) begin
              state_o.cursor = cfg_i.loop_start;
              if (loops_pos) begin
                state_o.loops = state_i.loops - 17'd1;
              end
            end else begin
              state_o.cursor = cur_inc;
              if (cur_inc >= cap) begin
                state_o.exhausted = 1'b1;
              end
            end
            state_o.pkt_cnt = close_w ? 13'd0 : cnt_inc[12:0];
          end
        end
      end
      OP_SET_POS: begin
        if (frame_i > cap) begin
          res_o.status = 1'b1;
        end else begin
          state_o.cancelled = cancel_w;
          state_o = cursor_reset(state_o, frame_i, cfg_i.loop_reps, cap);
        end
      end
      OP_RELOAD: begin
        state_o = cursor_reset(state_i, 24'd0, cfg_i.loop_reps, cap);
      end
      OP_LOADED: begin
        if (!state_i.loaded) begin
          state_o = cursor_reset(state_i, 24'd0, cfg_i.loop_reps, cap);
        end
        state_o.loaded = 1'b1;
      end
      default: ;
    endcase
    res_o.is_exhausted = state_o.exhausted;
  end

endmodule

`default_nettype wire

// ----- rtl/static_buffer_loop_cursor_core.sv -----
// Loop cursor core: command register, step logic, playback state and
// result register. Depends on sblc_pkg, the channel interfaces,
// sblc_cfg_regs, sblc_step and the assertion macro header.
//
// Each command transaction (tick, set position, reload, buffer loaded)
// yields exactly one result transaction. The block takes one command per
// clock when the result side keeps up; each command passes through the
// command register, then the result register, which offers its result.
// The rate is set by the playback state, which is read and rewritten by the
// step logic within the same cycle for every command. A result that waits to be
// taken does not stop the next command from entering the command register;
// the command after that waits until the result is taken.
// Configuration writes take effect on the next cycle and are meant for
// times when no command is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "static_buffer_loop_cursor_core_assert.svh"

module static_buffer_loop_cursor_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sblc_in_if.sink    in_i,
  sblc_out_if.source out_o,
  sblc_cfg_if.sink   cfg_i
);
  import sblc_pkg::*;

  cfg_t        cfg;
  logic        reps_wr;
  state_t      state_q;
  state_t      state_d;
  state_t      state_nxt;
  res_t        res;
  res_t        out_q;
  logic        out_valid_q;
  logic        cmd_valid_q;
  logic [1:0]  cmd_op_q;
  logic [23:0] cmd_frame_q;
  logic [23:0] cap;
  logic        out_free;
  logic        cmd_fire;
  logic        in_fire;

  sblc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .cfg_o     (cfg),
    .reps_wr_o (reps_wr)
  );

  sblc_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .op_i    (cmd_op_q),
    .frame_i (cmd_frame_q),
    .state_o (state_nxt),
    .res_o   (res),
    .cap_o   (cap)
  );

  // Handshake: result register frees up when empty or being taken
  assign out_free   = !out_valid_q || out_o.ready;
  assign cmd_fire   = cmd_valid_q && out_free;
  assign in_i.ready = !cmd_valid_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  // Command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      cmd_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_op_q    <= in_i.op;
      cmd_frame_q <= in_i.frame;
    end
  end

  // Advance playback state; a loop count write reloads the loop budget
  always_comb begin
    state_d = state_q;
    if (cmd_fire) begin
      state_d = state_nxt;
    end
    if (reps_wr) begin
      state_d.loops     = cfg_i.data[16:0];
      state_d.cancelled = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= cmd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      out_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.frame_index    = out_q.frame_index;
  assign out_o.frame_valid    = out_q.frame_valid;
  assign out_o.last_of_packet = out_q.last_of_packet;
  assign out_o.is_exhausted   = out_q.is_exhausted;
  assign out_o.status         = out_q.status;

  // An emitted frame always lies inside the buffer
  `SBLC_ASSERT_NOW(a_frame_in_buffer, cmd_fire && res.frame_valid,
                   ({1'b0, res.frame_index} < cap))

  // Nothing plays before the buffer is loaded
  `SBLC_ASSERT_NOW(a_no_frame_unloaded, cmd_fire && !state_q.loaded,
                   !res.frame_valid)

  // A rejected set position leaves the state untouched
  `SBLC_ASSERT_NEXT(a_reject_keeps_state, cmd_fire && res.status && !reps_wr,
                    state_q == $past(state_q))

  // A stalled command keeps its slot until the result register frees up
  `SBLC_ASSERT_NEXT(a_cmd_held, cmd_valid_q && !out_free,
                    cmd_valid_q && $stable(cmd_op_q) && $stable(cmd_frame_q))

endmodule

`default_nettype wire

// ----- tb/static_buffer_loop_cursor_core_checker.sv -----
`timescale 1ns / 1ps
// Passive checker for the loop cursor core: keeps its own copy of the
// configuration and playback state, predicts one result per command and
// compares it with the result transaction. Depends on sblc_pkg and the channel interfaces.

module static_buffer_loop_cursor_core_checker (
  input  logic clk_i,
  input  logic rst_ni,
  sblc_in_if   in_ch,
  sblc_out_if  out_ch,
  sblc_cfg_if  cfg_ch,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   emitted_o,
  output int   rejected_o
);
  import sblc_pkg::*;

  // Mirrored configuration
  logic        [23:0] capacity_q;
  logic        [23:0] loop_start_q;
  logic        [23:0] loop_end_q;
  logic signed [16:0] loop_reps_q;
  logic        [12:0] pkt_frames_q;

  // Mirrored playback state
  logic        [23:0] cursor_q;
  logic signed [16:0] loops_left_q;
  logic               exhausted_q;
  logic               loaded_q;
  logic               cancelled_q;
  logic        [12:0] pkt_cnt_q;

  res_t expected_results[$];

  // Jump the cursor to a target frame and rearm looping and packets
  function automatic void restart_at(logic [23:0] target, logic [23:0] cap);
    cursor_q     = target;
    loops_left_q = cancelled_q ? '0 : loop_reps_q;
    exhausted_q  = (target >= cap);
    pkt_cnt_q    = '0;
  endfunction

  // Apply one command to the mirrored state and return its result
  function automatic res_t play_command(op_e op, logic [23:0] frame);
    res_t        res;
    logic [23:0] cap;
    logic [23:0] bound;
    logic [12:0] pkt;
    logic        loop_on;
    res = '0;
    cap = (capacity_q > MAX_FRAMES) ? MAX_FRAMES : capacity_q;
    pkt = (pkt_frames_q == '0) ? 13'd1 : pkt_frames_q;
    case (op)
      OP_TICK: begin
        if (loaded_q && !exhausted_q) begin
          loop_on = (loops_left_q != 0) && (cursor_q < loop_end_q);
          bound   = loop_on ? loop_end_q : cap;
          if (cursor_q >= bound || cursor_q >= cap) begin
            // Playback ran into its end: no frame, close the packet
            exhausted_q        = 1'b1;
            res.last_of_packet = 1'b1;
            pkt_cnt_q          = '0;
          end else begin
            res.frame_index = cursor_q[22:0];
            res.frame_valid = 1'b1;
            cursor_q        = cursor_q + 24'd1;
            pkt_cnt_q       = pkt_cnt_q + 13'd1;
            if (cursor_q == loop_end_q && loops_left_q != 0) begin
              cursor_q = loop_start_q;
              if (loops_left_q > 0) loops_left_q = loops_left_q - 17'sd1;
            end else if (cursor_q >= cap) begin
              exhausted_q        = 1'b1;
              res.last_of_packet = 1'b1;
            end
            if (pkt_cnt_q >= pkt) res.last_of_packet = 1'b1;
            if (res.last_of_packet) pkt_cnt_q = '0;
          end
        end
      end
      OP_SET_POS: begin
        if (frame > cap) begin
          res.status = 1'b1;
        end else begin
          // Seeking at or past the loop end drops looping until rearmed
          if (loop_reps_q != 0 && !cancelled_q && frame >= loop_end_q) cancelled_q = 1'b1;
          restart_at(frame, cap);
        end
      end
      OP_RELOAD: begin
        restart_at('0, cap);
      end
      default: begin
        if (!loaded_q) restart_at('0, cap);
        loaded_q = 1'b1;
      end
    endcase
    res.is_exhausted = exhausted_q;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    res_t exp_res;
    if (!rst_ni) begin
      capacity_q   = 24'd1;
      loop_start_q = '0;
      loop_end_q   = '0;
      loop_reps_q  = '0;
      pkt_frames_q = 13'd480;
      cursor_q     = '0;
      loops_left_q = '0;
      exhausted_q  = 1'b0;
      loaded_q     = 1'b0;
      cancelled_q  = 1'b0;
      pkt_cnt_q    = '0;
      expected_results.delete();
      fail_count_o = 0;
      checked_o    = 0;
      emitted_o    = 0;
      rejected_o   = 0;
    end else begin
      // Compare a result transaction with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no command outstanding");
          fail_count_o++;
        end else begin
          exp_res = expected_results[0];
          expected_results.delete(0);
          check_field("frame_index", 32'(exp_res.frame_index), 32'(out_ch.frame_index));
          check_field("frame_valid", 32'(exp_res.frame_valid), 32'(out_ch.frame_valid));
          check_field("last_of_packet", 32'(exp_res.last_of_packet),
                      32'(out_ch.last_of_packet));
          check_field("is_exhausted", 32'(exp_res.is_exhausted), 32'(out_ch.is_exhausted));
          check_field("status", 32'(exp_res.status), 32'(out_ch.status));
          checked_o++;
          if (exp_res.frame_valid) emitted_o++;
          if (exp_res.status) rejected_o++;
        end
      end

      // Track register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_CAPACITY:   capacity_q   = cfg_ch.data;
          CFG_LOOP_START: loop_start_q = cfg_ch.data;
          CFG_LOOP_END:   loop_end_q   = cfg_ch.data;
          CFG_LOOP_COUNT: begin
            loop_reps_q  = cfg_ch.data[16:0];
            loops_left_q = cfg_ch.data[16:0];
            cancelled_q  = 1'b0;
          end
          CFG_PKT_FRAMES: pkt_frames_q = cfg_ch.data[12:0];
          default: ;
        endcase
      end

      // Predict the result of each accepted command
      if (in_ch.valid && in_ch.ready) begin
        expected_results = {expected_results, play_command(op_e'(in_ch.op), in_ch.frame)};
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ----- tb/static_buffer_loop_cursor_core_tb.sv -----
`timescale 1ns / 1ps
// Top of the loop cursor core testbench: clock, reset, command and register
// traffic, result back-pressure and the verdict. Depends on sblc_pkg, the channel interfaces,
// the core and static_buffer_loop_cursor_core_checker.

module static_buffer_loop_cursor_core_tb;
  import sblc_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int SETTLE_TICKS = 8;
  localparam int LONG_HOLD    = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sblc_in_if  in_ch ();
  sblc_out_if out_ch ();
  sblc_cfg_if cfg_ch ();

  int fail_count;
  int pending;
  int checked;
  int emitted;
  int rejected;
  int cmd_count   = 0;
  int cfg_count   = 0;
  int idle_cycles = 0;
  int rx_hold_req = 0;
  int tx_burst    = 0;
  int rx_burst    = 0;
  bit tx_quiet;
  bit rx_quiet;

  logic [23:0] cur_cap;
  logic [23:0] cur_loop_start;
  logic [23:0] cur_loop_end;

  static_buffer_loop_cursor_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  static_buffer_loop_cursor_core_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .emitted_o   (emitted),
    .rejected_o  (rejected)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Offer one command after a random gap and hold it until taken
  task automatic send_cmd(op_e op, logic [23:0] frame);
    int gap;
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(40, 1);
      tx_quiet = ($urandom_range(3, 0) == 0);
    end
    tx_burst--;
    gap = tx_quiet ? 0 : $urandom_range(12, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.frame <= frame;
    do @(posedge clk_i); while (!in_ch.ready);
    cmd_count++;
  endtask

  // Stop offering and wait until every result transaction has come back;
  // the extra edge lets the checker count the last accepted command first
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Write all five registers back to back; call only while idle
  task automatic write_config(logic [23:0] cap, logic [23:0] ls, logic [23:0] le,
                              logic [16:0] lc, logic [12:0] pf);
    logic [23:0] vals [5];
    vals[CFG_CAPACITY]   = cap;
    vals[CFG_LOOP_START] = ls;
    vals[CFG_LOOP_END]   = le;
    vals[CFG_LOOP_COUNT] = {7'd0, lc};
    vals[CFG_PKT_FRAMES] = {11'd0, pf};
    for (int i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= cfg_idx_e'(i);
      cfg_ch.data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ch.ready);
    end
    cfg_ch.valid   <= 1'b0;
    cur_cap        = cap;
    cur_loop_start = ls;
    cur_loop_end   = le;
    cfg_count++;
  endtask

  // Mostly small buffers with loops inside them, now and then huge or empty ones
  task automatic random_config();
    logic [23:0] cap;
    logic [23:0] ls;
    logic [23:0] le;
    logic [16:0] lc;
    logic [12:0] pf;
    int unsigned ecap;
    case ($urandom_range(9, 0))
      6:       cap = '0;
      7:       cap = 24'($urandom_range(32'h0080_0010, 32'h007F_FFF0));
      8:       cap = 24'($urandom());
      9:       cap = 24'($urandom_range(5000, 49));
      default: cap = 24'($urandom_range(48, 1));
    endcase
    ecap = (cap > MAX_FRAMES) ? MAX_FRAMES : cap;
    ls = 24'($urandom_range(ecap + 2, 0));
    le = 24'($urandom_range(ecap + 4, 0));
    if ($urandom_range(3, 0) != 0 && ls > le) begin
      ls = ls ^ le;
      le = ls ^ le;
      ls = ls ^ le;
    end
    case ($urandom_range(4, 0))
      0:       lc = '0;
      1:       lc = '1;
      4:       lc = 17'($urandom());
      default: lc = 17'($urandom_range(5, 1));
    endcase
    case ($urandom_range(5, 0))
      0:       pf = '0;
      1:       pf = 13'($urandom());
      default: pf = 13'($urandom_range(12, 1));
    endcase
    write_config(cap, ls, le, lc, pf);
  endtask

  // Seek targets clustered around the loop points and the buffer end
  function automatic logic [23:0] pick_frame();
    int unsigned ecap;
    int unsigned f;
    ecap = (cur_cap > MAX_FRAMES) ? MAX_FRAMES : cur_cap;
    case ($urandom_range(7, 0))
      1:       f = (cur_loop_end > 2) ? cur_loop_end - $urandom_range(2, 0) : cur_loop_end;
      2:       f = (ecap >= 3) ? ecap - $urandom_range(3, 0) : ecap;
      3:       f = ecap + 1;
      4:       f = $urandom();
      5:       f = cur_loop_start + $urandom_range(3, 0);
      default: f = $urandom_range(ecap, 0);
    endcase
    return f[23:0];
  endfunction

  // Result side: random stalls, quiet stretches and one long hold on request
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_burst == 0) begin
        rx_burst = $urandom_range(40, 1);
        rx_quiet = ($urandom_range(3, 0) == 0);
      end
      rx_burst--;
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(12, 0);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || !rst_ni)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("static_buffer_loop_cursor_core verification failed");
    $finish;
  end

  initial begin : stimulus
    int r;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_TICK;
    in_ch.frame    <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_CAPACITY;
    cfg_ch.data    <= '0;
    cur_cap        = 24'd1;
    cur_loop_start = '0;
    cur_loop_end   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one-frame buffer, no loop
    send_cmd(OP_TICK, 24'($urandom()));         // tick before any load
    send_cmd(OP_SET_POS, 24'd0);                // seek while unloaded
    send_cmd(OP_LOADED, 24'($urandom()));       // first load rewinds
    send_cmd(OP_TICK, 24'($urandom()));         // only frame, ends playback
    send_cmd(OP_TICK, 24'($urandom()));         // tick while exhausted
    send_cmd(OP_SET_POS, 24'd2);                // beyond capacity, rejected
    send_cmd(OP_SET_POS, 24'd1);                // exactly capacity, exhausted
    send_cmd(OP_RELOAD, 24'($urandom()));
    send_cmd(OP_LOADED, 24'($urandom()));       // later load keeps the cursor
    send_cmd(OP_SET_POS, 24'hFF_FFFF);
    drain();

    // Oversized capacity clamps; loop 2..4 once, packets of three
    write_config(24'hFF_FFFF, 24'd2, 24'd5, 17'd1, 13'd3);
    send_cmd(OP_RELOAD, 24'($urandom()));
    repeat (7) send_cmd(OP_TICK, 24'($urandom()));
    send_cmd(OP_SET_POS, 24'h7F_FFFE);          // seek past loop end cancels looping
    repeat (3) send_cmd(OP_TICK, 24'($urandom()));
    send_cmd(OP_SET_POS, 24'h80_0000);
    send_cmd(OP_SET_POS, 24'h80_0001);
    drain();

    // Empty buffer, endless loop count, zero packet size
    write_config('0, '0, 24'd3, '1, '0);
    send_cmd(OP_RELOAD, 24'($urandom()));
    send_cmd(OP_TICK, 24'($urandom()));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       write_config(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 17'h0_FFFF, 13'h1FFF);
        1:       write_config('0, '0, '0, 17'h1_0000, '0);
        2:       write_config(24'd1, '0, 24'd1, '1, 13'd1);
        default: random_config();
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 4 && n == 40) rx_hold_req = LONG_HOLD;
        if (phase == 6 && n == 75) drain();
        r = $urandom_range(99, 0);
        if (r < 64)      send_cmd(OP_TICK, 24'($urandom()));
        else if (r < 80) send_cmd(OP_SET_POS, pick_frame());
        else if (r < 91) send_cmd(OP_RELOAD, 24'($urandom()));
        else             send_cmd(OP_LOADED, 24'($urandom()));
      end
      drain();
    end

    repeat (SETTLE_TICKS) @(posedge clk_i);
    $display("Ran %0d commands under %0d register settings: %0d results checked,",
             cmd_count, cfg_count, checked);
    $display("%0d frames emitted, %0d seeks rejected", emitted, rejected);
    if (fail_count == 0 && pending == 0)
      $display("static_buffer_loop_cursor_core verification clean");
    else
      $display("static_buffer_loop_cursor_core verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sblc_pkg.sv
rtl/sblc_in_if.sv
rtl/sblc_out_if.sv
rtl/sblc_cfg_if.sv
rtl/sblc_cfg_regs.sv
rtl/sblc_step.sv
rtl/static_buffer_loop_cursor_core.sv
tb/static_buffer_loop_cursor_core_checker.sv
tb/static_buffer_loop_cursor_core_tb.sv
